// ===== rtl/core/gtpc_pkg.sv =====
// Shared types and constants for the greedy tree point chain order core.
// No dependencies.
`default_nettype none
package gtpc_pkg;

	localparam int GTPC_MAX_POINTS = 64;
	localparam int COORD_W = 16;
	localparam int SQ_W = 32;
	localparam int DIST_W = 34;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic sq_en;
		logic acc_clr;
		logic acc_en;
	} dist_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/gtpc_dist.sv =====
// Shared squared-distance unit: one axis square per cycle while ctl.sq_en is set, accumulated.
// Depends on gtpc_pkg.
`default_nettype none
module gtpc_dist import gtpc_pkg::*; (
	input  wire logic                      clk,
	input  wire dist_ctl_t                 ctl,
	input  wire logic signed [COORD_W-1:0] a,
	input  wire logic signed [COORD_W-1:0] b,
	output logic        [DIST_W-1:0]       dsq
);

	logic signed [COORD_W:0]     diff;
	logic signed [2*COORD_W+1:0] prod;
	logic        [SQ_W-1:0]      sq_q;
	logic        [DIST_W-1:0]    acc_q;

	assign diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
	assign prod = diff * diff;
	assign dsq  = acc_q + {{(DIST_W-SQ_W){1'b0}}, sq_q};

	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			sq_q <= prod[SQ_W-1:0];
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + {{(DIST_W-SQ_W){1'b0}}, sq_q};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/greedy_tree_point_chain_order_core.sv =====
// Loading takes one point per accepted start; ordering n points scans all chosen/unchosen
// pairs each round through one shared squarer (pair select, x, y and z squares, compare),
// plus list search and insert shifts, then reads and emits each point in chain order.
// busy stays high from the last-marked point until the final result; results cannot stall.
// Reset (arst_n low) returns to idle with an empty point set.
`default_nettype none
module greedy_tree_point_chain_order_core import gtpc_pkg::*; #(
	parameter int MAX_POINTS = GTPC_MAX_POINTS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [COORD_W-1:0] px,
	input  wire logic signed [COORD_W-1:0] py,
	input  wire logic signed [COORD_W-1:0] pz,
	input  wire logic                      in_last,
	output logic                           out_valid,
	output logic signed [COORD_W-1:0]      qx,
	output logic signed [COORD_W-1:0]      qy,
	output logic signed [COORD_W-1:0]      qz,
	output logic                           out_last
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [4:0] S_IDLE = 5'd0,  S_INIT = 5'd1,  S_SM = 5'd2,   S_SMW = 5'd3;
	localparam logic [4:0] S_SJ = 5'd4,    S_AX0 = 5'd5,   S_AX1 = 5'd6,  S_AX2 = 5'd7;
	localparam logic [4:0] S_CMP = 5'd8,   S_RE = 5'd9,    S_R0B = 5'd10, S_FRD = 5'd11;
	localparam logic [4:0] S_FRD2 = 5'd12, S_FCMP = 5'd13, S_IPOS = 5'd14, S_IRD = 5'd15;
	localparam logic [4:0] S_IWR = 5'd16,  S_IPUT = 5'd17, S_ENX = 5'd18, S_ERD = 5'd19;
	localparam logic [4:0] S_ERD2 = 5'd20, S_EOUT = 5'd21;

	logic [4:0]            state_q;
	logic [CW-1:0]         count_q, n_q, m_q, j_q, k_q, len_q, round_q, idx_q, pos_q;
	logic [CW-1:0]         bc_q, off_q, add_q;
	logic [MAX_POINTS-1:0] chosen_q;
	logic [AW-1:0]         a_q, b_q, prev_q;
	logic                  found_q;
	logic [DIST_W-1:0]     best_q;
	point_t                p0_q, pm_q, pa_q, bpc_q, tgt_q;

	point_t                st_mem [MAX_POINTS];
	point_t                st_rd_q;
	logic                  st_re;
	logic [AW-1:0]         st_ra;
	logic [AW-1:0]         ol_mem [MAX_POINTS];
	logic [AW-1:0]         ol_rd_q;
	logic                  ol_re, ol_we;
	logic [AW-1:0]         ol_ra, ol_wa, ol_wd;

	logic                  accept, last_emit, new_br;
	logic [CW-1:0]         n_next, bc_next, pos_c;
	logic [CW:0]           pos_sum;
	dist_ctl_t             dctl;
	logic signed [COORD_W-1:0] da, db;
	logic [DIST_W-1:0]     dsq;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign n_next    = (count_q < CW'(MAX_POINTS)) ? count_q + 1'b1 : count_q;
	assign out_valid = (state_q == S_EOUT);
	assign qx        = st_rd_q.x;
	assign qy        = st_rd_q.y;
	assign qz        = st_rd_q.z;
	assign last_emit = (k_q + 1'b1 == len_q);
	assign out_last  = out_valid && last_emit;
	assign new_br    = (prev_q != a_q);
	assign bc_next   = new_br ? bc_q + 1'b1 : bc_q;
	assign pos_sum   = {1'b0, k_q} + {1'b0, add_q};
	assign pos_c     = (pos_sum > {1'b0, len_q}) ? len_q : pos_sum[CW-1:0];

	always_comb begin
		dctl = '0;
		da   = pm_q.x;
		db   = st_rd_q.x;
		case (state_q)
			S_AX0: begin
				dctl.sq_en   = 1'b1;
				dctl.acc_clr = 1'b1;
			end
			S_AX1: begin
				dctl.sq_en  = 1'b1;
				dctl.acc_en = 1'b1;
				da          = pm_q.y;
				db          = st_rd_q.y;
			end
			S_AX2: begin
				dctl.sq_en  = 1'b1;
				dctl.acc_en = 1'b1;
				da          = pm_q.z;
				db          = st_rd_q.z;
			end
			default: ;
		endcase
	end

	gtpc_dist u_dist (
		.clk  (clk),
		.ctl  (dctl),
		.a    (da),
		.b    (db),
		.dsq  (dsq)
	);

	always_comb begin
		st_re = 1'b0;
		st_ra = ol_rd_q;
		ol_re = 1'b0;
		ol_ra = k_q[AW-1:0];
		ol_we = 1'b0;
		ol_wa = a_q;
		ol_wd = a_q;
		unique case (state_q)
			S_SM: begin
				st_re = (m_q != n_q) && chosen_q[m_q[AW-1:0]];
				st_ra = m_q[AW-1:0];
			end
			S_SJ: begin
				st_re = (j_q != n_q) && !chosen_q[j_q[AW-1:0]];
				st_ra = j_q[AW-1:0];
			end
			S_FRD, S_ERD: ol_re = (state_q == S_ERD) || (k_q != len_q);
			S_FRD2, S_ERD2: st_re = 1'b1;
			S_INIT: begin
				ol_we = (n_q <= CW'(1));
				ol_wa = '0;
				ol_wd = '0;
			end
			S_RE: begin
				ol_we = (round_q == '0);
				ol_wa = '0;
			end
			S_R0B: begin
				ol_we = 1'b1;
				ol_wa = AW'(1);
				ol_wd = b_q;
			end
			S_IRD: begin
				ol_re = 1'b1;
				ol_ra = idx_q[AW-1:0] - 1'b1;
			end
			S_IWR: begin
				ol_we = 1'b1;
				ol_wa = idx_q[AW-1:0];
				ol_wd = ol_rd_q;
			end
			S_IPUT: begin
				ol_we = 1'b1;
				ol_wa = pos_q[AW-1:0];
				ol_wd = b_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && (count_q < CW'(MAX_POINTS))) begin
			st_mem[count_q[AW-1:0]] <= '{x: px, y: py, z: pz};
		end
		if (st_re) begin
			st_rd_q <= st_mem[st_ra];
		end
		if (ol_we) begin
			ol_mem[ol_wa] <= ol_wd;
		end
		if (ol_re) begin
			ol_rd_q <= ol_mem[ol_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (count_q == '0)) begin
			p0_q <= '{x: px, y: py, z: pz};
		end
		if (state_q == S_SMW) begin
			pm_q <= st_rd_q;
		end
		if (state_q == S_ENX || state_q == S_INIT) begin
			pa_q <= p0_q;
		end else if (state_q == S_CMP && dsq != '0 && (!found_q || dsq < best_q)) begin
			pa_q <= pm_q;
		end
		if (state_q == S_CMP && dsq != '0 && (!found_q || dsq < best_q)) begin
			best_q <= dsq;
		end
		if (state_q == S_RE && round_q != '0) begin
			if (new_br) begin
				bpc_q <= pa_q;
			end
			tgt_q <= (bc_next[0] || new_br) ? pa_q : bpc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			n_q      <= '0;
			m_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			len_q    <= '0;
			round_q  <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			bc_q     <= '0;
			off_q    <= '0;
			add_q    <= '0;
			chosen_q <= '0;
			a_q      <= '0;
			b_q      <= '0;
			prev_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= n_next;
						if (in_last) begin
							n_q     <= n_next;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					chosen_q    <= MAX_POINTS'(1);
					prev_q      <= '0;
					bc_q        <= '0;
					off_q       <= '0;
					round_q     <= '0;
					m_q         <= '0;
					k_q         <= '0;
					found_q     <= 1'b0;
					a_q         <= '0;
					b_q         <= '0;
					if (n_q <= CW'(1)) begin
						len_q   <= CW'(1);
						state_q <= S_ERD;
					end else begin
						len_q   <= '0;
						state_q <= S_SM;
					end
				end
				S_SM: begin
					if (m_q == n_q) begin
						state_q <= S_RE;
					end else if (!chosen_q[m_q[AW-1:0]]) begin
						m_q <= m_q + 1'b1;
					end else begin
						state_q <= S_SMW;
					end
				end
				S_SMW: begin
					j_q     <= '0;
					state_q <= S_SJ;
				end
				S_SJ: begin
					if (j_q == n_q) begin
						m_q     <= m_q + 1'b1;
						state_q <= S_SM;
					end else if (chosen_q[j_q[AW-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_AX0;
					end
				end
				S_AX0: state_q <= S_AX1;
				S_AX1: state_q <= S_AX2;
				S_AX2: state_q <= S_CMP;
				S_CMP: begin
					if (dsq != '0 && (!found_q || dsq < best_q)) begin
						found_q <= 1'b1;
						a_q     <= m_q[AW-1:0];
						b_q     <= j_q[AW-1:0];
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_SJ;
				end
				S_RE: begin
					k_q <= '0;
					if (round_q == '0) begin
						state_q <= S_R0B;
					end else begin
						if (new_br) begin
							bc_q <= bc_next;
						end
						if (bc_next[0]) begin
							add_q   <= '0;
							state_q <= S_FRD;
						end else if (bc_next != '0) begin
							add_q   <= new_br ? CW'(1) : off_q;
							off_q   <= (new_br ? CW'(1) : off_q) + 1'b1;
							state_q <= S_FRD;
						end else begin
							add_q   <= '0;
							k_q     <= len_q;
							state_q <= S_IPOS;
						end
					end
				end
				S_R0B: begin
					len_q   <= CW'(2);
					state_q <= S_ENX;
				end
				S_FRD: state_q <= (k_q == len_q) ? S_IPOS : S_FRD2;
				S_FRD2: state_q <= S_FCMP;
				S_FCMP: begin
					if (st_rd_q == tgt_q) begin
						state_q <= S_IPOS;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_IPOS: begin
					pos_q   <= pos_c;
					idx_q   <= len_q;
					state_q <= (pos_c == len_q) ? S_IPUT : S_IRD;
				end
				S_IRD: state_q <= S_IWR;
				S_IWR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= (idx_q - 1'b1 == pos_q) ? S_IPUT : S_IRD;
				end
				S_IPUT: begin
					len_q   <= len_q + 1'b1;
					state_q <= S_ENX;
				end
				S_ENX: begin
					chosen_q[b_q] <= 1'b1;
					prev_q        <= b_q;
					round_q       <= round_q + 1'b1;
					m_q           <= '0;
					k_q           <= '0;
					found_q       <= 1'b0;
					a_q           <= '0;
					b_q           <= '0;
					if ({1'b0, round_q} + (CW+1)'(2) < {1'b0, n_q}) begin
						state_q <= S_SM;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_ERD2;
				S_ERD2: state_q <= S_EOUT;
				S_EOUT: begin
					if (last_emit) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_ERD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> busy)
		else $error("result strobe while not busy");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |=> !busy)
		else $error("not idle after last result");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !in_last |=> !busy)
		else $error("non-last transaction left block busy");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= n_q || state_q == S_IDLE || state_q == S_INIT)
		else $error("list longer than point set");
`endif

endmodule
`default_nettype wire

// ===== test/greedy_tree_point_chain_order_core_tb.sv =====
// Testbench for greedy_tree_point_chain_order_core: loads point sets and checks the emitted
// chain order against an in-bench tree-growth predictor. Depends on gtpc_pkg and the core.
`default_nettype none
module greedy_tree_point_chain_order_core_tb;
	import gtpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COORD_W-1:0] px = '0, py = '0, pz = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic signed [COORD_W-1:0] qx, qy, qz;
	logic out_last;

	typedef struct {
		point_t p;
		logic last;
	} chain_pt_t;

	point_t loaded_pts[GTPC_MAX_POINTS];
	int loaded_cnt = 0;
	chain_pt_t chain_expected[$];
	int mismatches = 0;
	int sender_idle_pct = 0;
	longint cycles = 0;

	greedy_tree_point_chain_order_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.px(px), .py(py), .pz(pz), .in_last(in_last),
		.out_valid(out_valid), .qx(qx), .qy(qy), .qz(qz), .out_last(out_last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic longint sq_dist(input point_t a, input point_t b);
		longint dx, dy, dz;
		dx = longint'(a.x) - longint'(b.x);
		dy = longint'(a.y) - longint'(b.y);
		dz = longint'(a.z) - longint'(b.z);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic int list_pos_of(input int chain[$], input point_t p);
		foreach (chain[k])
			if (loaded_pts[chain[k]] == p)
				return k;
		return chain.size();
	endfunction

	task automatic predict_chain(input int n);
		bit chosen[GTPC_MAX_POINTS];
		int chain[$];
		int prev_child, branch_pt;
		logic [6:0] branch_cnt, ins_off;
		bit found;
		longint best, d;
		int a, b, pos;
		chain_pt_t cp;
		chain = {};
		prev_child = 0;
		branch_pt = 0;
		branch_cnt = '0;
		ins_off = '0;
		foreach (chosen[i])
			chosen[i] = 1'b0;
		chosen[0] = 1'b1;
		if (n <= 1)
			chain.insert(chain.size(), 0);
		for (int r = 0; r + 1 < n; r++) begin
			found = 1'b0;
			best = 0;
			a = 0;
			b = 0;
			for (int m = 0; m < n; m++) begin
				if (!chosen[m])
					continue;
				for (int j = 0; j < n; j++) begin
					if (chosen[j])
						continue;
					d = sq_dist(loaded_pts[m], loaded_pts[j]);
					if (d != 0 && (!found || d < best)) begin
						found = 1'b1;
						best = d;
						a = m;
						b = j;
					end
				end
			end
			if (r == 0) begin
				chain.insert(chain.size(), a);
				chain.insert(chain.size(), b);
			end else begin
				if (prev_child != a) begin
					branch_cnt = branch_cnt + 7'd1;
					branch_pt = a;
					ins_off = 7'd1;
				end
				if (branch_cnt[0])
					pos = list_pos_of(chain, loaded_pts[a]);
				else if (branch_cnt != 0) begin
					pos = list_pos_of(chain, loaded_pts[branch_pt]) + int'(ins_off);
					ins_off = ins_off + 7'd1;
				end else
					pos = chain.size();
				if (pos > chain.size())
					pos = chain.size();
				if (chain.size() < GTPC_MAX_POINTS)
					chain.insert(pos, b);
			end
			prev_child = b;
			chosen[b] = 1'b1;
		end
		foreach (chain[k]) begin
			cp.p = loaded_pts[chain[k]];
			cp.last = (k + 1 == chain.size());
			chain_expected.insert(chain_expected.size(), cp);
		end
	endtask

	task automatic send_point(input point_t p, input logic last);
		logic was_busy;
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		px <= p.x;
		py <= p.y;
		pz <= p.z;
		in_last <= last;
		forever begin
			was_busy = busy;
			@(posedge clk);
			if (!was_busy)
				break;
			@(negedge clk);
		end
		if (loaded_cnt < GTPC_MAX_POINTS) begin
			loaded_pts[loaded_cnt] = p;
			loaded_cnt++;
		end
		if (last) begin
			predict_chain(loaded_cnt);
			loaded_cnt = 0;
		end
		@(negedge clk);
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (chain_expected.size() == 0)
				report($sformatf("unexpected point (%0d,%0d,%0d)", qx, qy, qz));
			else begin
				chain_pt_t e;
				e = chain_expected.pop_front();
				if (qx !== e.p.x)
					report($sformatf("qx %0d exp %0d", qx, e.p.x));
				if (qy !== e.p.y)
					report($sformatf("qy %0d exp %0d", qy, e.p.y));
				if (qz !== e.p.z)
					report($sformatf("qz %0d exp %0d", qz, e.p.z));
				if (out_last !== e.last)
					report($sformatf("out_last %0b exp %0b", out_last, e.last));
			end
		end
	end

	function automatic point_t mk(input int x, input int y, input int z);
		point_t p;
		p.x = x[15:0];
		p.y = y[15:0];
		p.z = z[15:0];
		return p;
	endfunction

	function automatic point_t rand_point(input bit tight);
		if (tight)
			return mk($urandom_range(6) - 3, $urandom_range(6) - 3, $urandom_range(6) - 3);
		return mk($urandom, $urandom, $urandom);
	endfunction

	task automatic test_single_point();
		send_point(mk(-32768, 32767, 0), 1'b1);
	endtask

	task automatic test_extremes();
		send_point(mk(-32768, -32768, -32768), 1'b0);
		send_point(mk(32767, 32767, 32767), 1'b0);
		send_point(mk(-1, 0, 1), 1'b1);
	endtask

	task automatic test_coincident();
		send_point(mk(5, 5, 5), 1'b0);
		send_point(mk(5, 5, 5), 1'b0);
		send_point(mk(5, 5, 5), 1'b0);
		send_point(mk(6, 5, 5), 1'b1);
	endtask

	task automatic test_branching();
		// star around origin with equal arms: ties and many branch switches
		send_point(mk(0, 0, 0), 1'b0);
		send_point(mk(1, 0, 0), 1'b0);
		send_point(mk(-1, 0, 0), 1'b0);
		send_point(mk(0, 1, 0), 1'b0);
		send_point(mk(0, -1, 0), 1'b0);
		send_point(mk(2, 0, 0), 1'b0);
		send_point(mk(0, 2, 0), 1'b0);
		send_point(mk(0, 0, 3), 1'b0);
		send_point(mk(-2, -1, 0), 1'b0);
		send_point(mk(1, 1, 0), 1'b1);
	endtask

	task automatic test_store_full();
		for (int i = 0; i < GTPC_MAX_POINTS + 2; i++)
			send_point(rand_point(1'($urandom_range(1))), i == GTPC_MAX_POINTS + 1);
		for (int i = 0; i < GTPC_MAX_POINTS; i++)
			send_point(rand_point(1'b1), i == GTPC_MAX_POINTS - 1);
	endtask

	task automatic test_random_sets(input int idle_pct, input int n_items);
		int sent, sz;
		bit tight;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < n_items) begin
			sz = $urandom_range(9, 0) == 0 ? $urandom_range(16, 9) : $urandom_range(8, 1);
			tight = 1'($urandom_range(1));
			for (int i = 0; i < sz; i++)
				send_point(rand_point(tight), i == sz - 1);
			sent += sz;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 26;
		test_single_point();
		test_extremes();
		test_coincident();
		test_branching();
		test_random_sets(26, 67);
		test_store_full();
		test_random_sets(72, 67);
		test_random_sets(0, 67);
		while (chain_expected.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/gtpc_pkg.sv
rtl/core/gtpc_dist.sv
rtl/core/greedy_tree_point_chain_order_core.sv
test/greedy_tree_point_chain_order_core_tb.sv
